>>> design/assert_macros.svh
// assertion macros used by the top-level design file
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH
`ifndef ASSERT_OFF
`define ASSERT_ALWAYS(lbl, clk, rst, prop) \
   lbl: assert property (@(posedge clk) disable iff (rst) (prop)) \
      else $error("assertion failed");
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed");
`define ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed");
`else
`define ASSERT_ALWAYS(lbl, clk, rst, prop)
`define ASSERT_IMPLIES(lbl, clk, rst, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst, ante, cons)
`endif
`endif

>>> design/lbs_pkg.sv
// shared types, constants and helpers of the skinning block
package lbs_pkg;
   localparam int unsigned DEF_NUM_BONES      = 256;
   localparam int unsigned DEF_MAX_INFLUENCES = 4;
   localparam int unsigned MAT_WORDS          = 12;
   localparam int unsigned MAT_COLS           = 4;
   localparam int unsigned TRANS_COL          = 3;
   localparam int unsigned AXES               = 3;
   localparam int unsigned COORD_W            = 32;
   localparam int unsigned PROD_W             = 2 * COORD_W;
   localparam int unsigned XSUM_W             = 50;
   localparam int unsigned WEIGHT_W           = 16;
   localparam int unsigned WPROD_W            = COORD_W + WEIGHT_W + 1;
   localparam int unsigned BONE_W             = 8;
   localparam int unsigned ELEM_W             = 4;
   localparam int unsigned COUNT_W            = 3;
   localparam int unsigned IDX_W              = 32;
   localparam int unsigned WTS_W              = 63;
   // weight field widened to four whole lanes, top bit reads as zero
   localparam int unsigned WTS_EXT_W          = 4 * WEIGHT_W;
   localparam int unsigned MAT_FRAC           = 16;
   localparam int unsigned WEIGHT_FRAC        = 15;

   // request tdata layout
   localparam int unsigned REQ_BONE_LSB  = 0;
   localparam int unsigned REQ_ELEM_LSB  = 8;
   localparam int unsigned REQ_VALUE_LSB = 12;
   localparam int unsigned REQ_X_LSB     = 44;
   localparam int unsigned REQ_Y_LSB     = 76;
   localparam int unsigned REQ_Z_LSB     = 108;
   localparam int unsigned REQ_IDX_LSB   = 140;
   localparam int unsigned REQ_WTS_LSB   = 172;
   localparam int unsigned REQ_TDATA_W   = 240;
   localparam int unsigned RSP_TDATA_W   = 104;

   typedef enum logic {
      CMD_PALETTE = 1'b0,
      CMD_VERTEX  = 1'b1
   } cmd_type;

   // control travelling with each pipeline stage
   typedef struct packed {
      logic               valid;
      logic [COUNT_W-1:0] used;
   } stage_ctl_type;

   function automatic logic signed [COORD_W-1:0] sat_coord(input logic signed [PROD_W-1:0] v);
      logic signed [PROD_W-1:0] hi;
      logic signed [PROD_W-1:0] lo;
      hi = PROD_W'(signed'({1'b0, {(COORD_W-1){1'b1}}}));
      lo = PROD_W'(signed'({1'b1, {(COORD_W-1){1'b0}}}));
      if (v > hi) begin
         sat_coord = hi[COORD_W-1:0];
      end else if (v < lo) begin
         sat_coord = lo[COORD_W-1:0];
      end else begin
         sat_coord = v[COORD_W-1:0];
      end
   endfunction
endpackage

>>> design/lbs_ram.sv
// generic single-write, registered-read ram
module lbs_ram #(
   parameter int unsigned WIDTH = 32,
   parameter int unsigned DEPTH = 256
) (
   input  logic                                  clock,
   input  logic                                  we,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
   input  logic [WIDTH-1:0]                      wdata,
   input  logic                                  re,
   input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
   output logic [WIDTH-1:0]                      rdata
);
   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rdata_ff;

   // write port and registered read port
   always_ff @(posedge clock) begin
      if (we) begin
         mem[waddr] <= wdata;
      end
      if (re) begin
         rdata_ff <= mem[raddr];
      end
   end

   assign rdata = rdata_ff;
endmodule

>>> design/lbs_fetch.sv
// palette storage, matrix fetch and influence selection stage
module lbs_fetch #(
   parameter int unsigned NUM_BONES      = lbs_pkg::DEF_NUM_BONES,
   parameter int unsigned MAX_INFLUENCES = lbs_pkg::DEF_MAX_INFLUENCES
) (
   input  logic                                    clock,
   input  logic                                    reset,
   input  logic                                    advance,
   input  logic                                    accept,
   input  lbs_pkg::cmd_type                        cmd,
   input  logic [lbs_pkg::BONE_W-1:0]              matrix_bone,
   input  logic [lbs_pkg::ELEM_W-1:0]              matrix_element,
   input  logic [lbs_pkg::COORD_W-1:0]             matrix_value,
   input  logic signed [lbs_pkg::COORD_W-1:0]      pos_x,
   input  logic signed [lbs_pkg::COORD_W-1:0]      pos_y,
   input  logic signed [lbs_pkg::COORD_W-1:0]      pos_z,
   input  logic [lbs_pkg::IDX_W-1:0]               bone_indices,
   input  logic [lbs_pkg::WTS_W-1:0]               blend_weights,
   output lbs_pkg::stage_ctl_type                  ctl,
   output logic signed [lbs_pkg::COORD_W-1:0]      pos [lbs_pkg::AXES],
   output logic signed [lbs_pkg::COORD_W-1:0]      mat [MAX_INFLUENCES][lbs_pkg::MAT_WORDS],
   output logic                                    bone_ok [MAX_INFLUENCES],
   output logic [lbs_pkg::WEIGHT_W-1:0]            weight [MAX_INFLUENCES]
);
   localparam int unsigned AW = NUM_BONES > 1 ? $clog2(NUM_BONES) : 1;

   logic                          wr_ok;
   logic [lbs_pkg::WTS_EXT_W-1:0] wts_ext;
   logic [lbs_pkg::WEIGHT_W-1:0]  lane_w [MAX_INFLUENCES];
   logic [lbs_pkg::BONE_W-1:0]    lane_bone [MAX_INFLUENCES];
   logic                          lane_act [MAX_INFLUENCES];
   logic [lbs_pkg::COUNT_W-1:0]   used_cnt;
   lbs_pkg::stage_ctl_type        ctl_ff;
   logic signed [lbs_pkg::COORD_W-1:0] pos_ff [lbs_pkg::AXES];
   logic                          bone_ok_ff [MAX_INFLUENCES];
   logic [lbs_pkg::WEIGHT_W-1:0]  weight_ff [MAX_INFLUENCES];

   // palette write qualification
   assign wr_ok = accept && (cmd == lbs_pkg::CMD_PALETTE)
                  && ({1'b0, matrix_bone} < (lbs_pkg::BONE_W + 1)'(NUM_BONES))
                  && (matrix_element < lbs_pkg::ELEM_W'(lbs_pkg::MAT_WORDS));

   // last weight lane has only 15 bits, pad it
   assign wts_ext = {{(lbs_pkg::WTS_EXT_W - lbs_pkg::WTS_W){1'b0}}, blend_weights};

   // leading nonzero weights decide which influences take part
   always_comb begin
      logic run;
      run      = 1'b1;
      used_cnt = '0;
      for (int l = 0; l < MAX_INFLUENCES; l++) begin
         lane_w[l]    = wts_ext[lbs_pkg::WEIGHT_W*l +: lbs_pkg::WEIGHT_W];
         lane_bone[l] = bone_indices[lbs_pkg::BONE_W*l +: lbs_pkg::BONE_W];
         run          = run && (lane_w[l] != '0);
         lane_act[l]  = run;
         used_cnt     = used_cnt + lbs_pkg::COUNT_W'(run);
      end
   end

   // one copy of every matrix word per influence lane
   for (genvar l = 0; l < MAX_INFLUENCES; l++) begin : g_lane
      for (genvar e = 0; e < lbs_pkg::MAT_WORDS; e++) begin : g_word
         logic [lbs_pkg::COORD_W-1:0] rd;
         lbs_ram #(.WIDTH(lbs_pkg::COORD_W), .DEPTH(NUM_BONES)) u_ram (
            .clock (clock),
            .we    (wr_ok && (matrix_element == lbs_pkg::ELEM_W'(e))),
            .waddr (matrix_bone[AW-1:0]),
            .wdata (matrix_value),
            .re    (advance),
            .raddr (lane_bone[l][AW-1:0]),
            .rdata (rd)
         );
         assign mat[l][e] = signed'(rd);
      end
   end

   // stage control
   always_ff @(posedge clock) begin
      if (reset) begin
         ctl_ff <= '0;
      end else if (advance) begin
         ctl_ff.valid <= accept && (cmd == lbs_pkg::CMD_VERTEX);
         ctl_ff.used  <= used_cnt;
      end
   end

   // stage payload, lanes past the last influence use a zero matrix
   always_ff @(posedge clock) begin
      if (advance) begin
         pos_ff[0] <= pos_x;
         pos_ff[1] <= pos_y;
         pos_ff[2] <= pos_z;
         for (int l = 0; l < MAX_INFLUENCES; l++) begin
            bone_ok_ff[l] <= lane_act[l]
                             && ({1'b0, lane_bone[l]} < (lbs_pkg::BONE_W + 1)'(NUM_BONES));
            weight_ff[l]  <= lane_act[l] ? lane_w[l] : '0;
         end
      end
   end

   assign ctl     = ctl_ff;
   assign pos     = pos_ff;
   assign bone_ok = bone_ok_ff;
   assign weight  = weight_ff;
endmodule

>>> design/lbs_xform.sv
// bone matrix transform: product stage, then sum and saturate stage
module lbs_xform #(
   parameter int unsigned MAX_INFLUENCES = lbs_pkg::DEF_MAX_INFLUENCES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  lbs_pkg::stage_ctl_type              ctl_i,
   input  logic signed [lbs_pkg::COORD_W-1:0]  pos [lbs_pkg::AXES],
   input  logic signed [lbs_pkg::COORD_W-1:0]  mat [MAX_INFLUENCES][lbs_pkg::MAT_WORDS],
   input  logic                                bone_ok [MAX_INFLUENCES],
   input  logic [lbs_pkg::WEIGHT_W-1:0]        weight_i [MAX_INFLUENCES],
   output lbs_pkg::stage_ctl_type              ctl_o,
   output logic signed [lbs_pkg::COORD_W-1:0]  xf [MAX_INFLUENCES][lbs_pkg::AXES],
   output logic [lbs_pkg::WEIGHT_W-1:0]        weight_o [MAX_INFLUENCES]
);
   lbs_pkg::stage_ctl_type               prod_ctl_ff;
   lbs_pkg::stage_ctl_type               xf_ctl_ff;
   logic signed [lbs_pkg::PROD_W-1:0]    prod_ff [MAX_INFLUENCES][lbs_pkg::AXES][lbs_pkg::AXES];
   logic signed [lbs_pkg::COORD_W-1:0]   trans_ff [MAX_INFLUENCES][lbs_pkg::AXES];
   logic [lbs_pkg::WEIGHT_W-1:0]         wp_ff [MAX_INFLUENCES];
   logic signed [lbs_pkg::COORD_W-1:0]   xf_ff [MAX_INFLUENCES][lbs_pkg::AXES];
   logic [lbs_pkg::WEIGHT_W-1:0]         wx_ff [MAX_INFLUENCES];
   logic signed [lbs_pkg::COORD_W-1:0]   xf_in [MAX_INFLUENCES][lbs_pkg::AXES];

   // control of both stages
   always_ff @(posedge clock) begin
      if (reset) begin
         prod_ctl_ff <= '0;
         xf_ctl_ff   <= '0;
      end else if (advance) begin
         prod_ctl_ff <= ctl_i;
         xf_ctl_ff   <= prod_ctl_ff;
      end
   end

   // matrix times position, bones out of range use a zero matrix
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < MAX_INFLUENCES; l++) begin
            wp_ff[l] <= weight_i[l];
            for (int r = 0; r < lbs_pkg::AXES; r++) begin
               trans_ff[l][r] <= bone_ok[l] ? mat[l][r*lbs_pkg::MAT_COLS + lbs_pkg::TRANS_COL]
                                            : '0;
               for (int c = 0; c < lbs_pkg::AXES; c++) begin
                  prod_ff[l][r][c] <= bone_ok[l]
                     ? lbs_pkg::PROD_W'(mat[l][r*lbs_pkg::MAT_COLS + c]) * lbs_pkg::PROD_W'(pos[c])
                     : '0;
               end
            end
         end
      end
   end

   // floor to q16.16, add translation, saturate
   always_comb begin
      logic signed [lbs_pkg::XSUM_W-1:0] s;
      for (int l = 0; l < MAX_INFLUENCES; l++) begin
         for (int r = 0; r < lbs_pkg::AXES; r++) begin
            s = lbs_pkg::XSUM_W'(trans_ff[l][r]);
            for (int c = 0; c < lbs_pkg::AXES; c++) begin
               s = s + lbs_pkg::XSUM_W'(prod_ff[l][r][c] >>> lbs_pkg::MAT_FRAC);
            end
            xf_in[l][r] = lbs_pkg::sat_coord(lbs_pkg::PROD_W'(s));
         end
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         xf_ff <= xf_in;
         wx_ff <= wp_ff;
      end
   end

   assign ctl_o    = xf_ctl_ff;
   assign xf       = xf_ff;
   assign weight_o = wx_ff;
endmodule

>>> design/lbs_blend.sv
// weighting stage, then sum over influences into the output register
module lbs_blend #(
   parameter int unsigned MAX_INFLUENCES = lbs_pkg::DEF_MAX_INFLUENCES
) (
   input  logic                                clock,
   input  logic                                reset,
   input  logic                                advance,
   input  lbs_pkg::stage_ctl_type              ctl_i,
   input  logic signed [lbs_pkg::COORD_W-1:0]  xf [MAX_INFLUENCES][lbs_pkg::AXES],
   input  logic [lbs_pkg::WEIGHT_W-1:0]        weight [MAX_INFLUENCES],
   output lbs_pkg::stage_ctl_type              ctl_o,
   output logic signed [lbs_pkg::COORD_W-1:0]  skinned [lbs_pkg::AXES]
);
   lbs_pkg::stage_ctl_type              wt_ctl_ff;
   lbs_pkg::stage_ctl_type              out_ctl_ff;
   logic signed [lbs_pkg::WPROD_W-1:0]  wprod_ff [MAX_INFLUENCES][lbs_pkg::AXES];
   logic signed [lbs_pkg::COORD_W-1:0]  out_ff [lbs_pkg::AXES];
   logic signed [lbs_pkg::COORD_W-1:0]  out_in [lbs_pkg::AXES];

   always_ff @(posedge clock) begin
      if (reset) begin
         wt_ctl_ff  <= '0;
         out_ctl_ff <= '0;
      end else if (advance) begin
         wt_ctl_ff  <= ctl_i;
         out_ctl_ff <= wt_ctl_ff;
      end
   end

   // coordinate times weight, unused influences carry a zero weight
   always_ff @(posedge clock) begin
      if (advance) begin
         for (int l = 0; l < MAX_INFLUENCES; l++) begin
            for (int r = 0; r < lbs_pkg::AXES; r++) begin
               wprod_ff[l][r] <= lbs_pkg::WPROD_W'(xf[l][r])
                                 * lbs_pkg::WPROD_W'(signed'({1'b0, weight[l]}));
            end
         end
      end
   end

   // floor to q16.16, accumulate influences, saturate
   always_comb begin
      logic signed [lbs_pkg::PROD_W-1:0] acc;
      for (int r = 0; r < lbs_pkg::AXES; r++) begin
         acc = '0;
         for (int l = 0; l < MAX_INFLUENCES; l++) begin
            acc = acc + lbs_pkg::PROD_W'(wprod_ff[l][r] >>> lbs_pkg::WEIGHT_FRAC);
         end
         out_in[r] = lbs_pkg::sat_coord(acc);
      end
   end

   always_ff @(posedge clock) begin
      if (advance) begin
         out_ff <= out_in;
      end
   end

   assign ctl_o   = out_ctl_ff;
   assign skinned = out_ff;
endmodule

>>> design/linear_blend_skinning_top.sv
// Linear blend skinning with up to four bone influences per vertex.
// Input channel req_: tuser selects the transaction kind (0 palette word
// write, 1 vertex). A palette write stores one 3x4 matrix word and gives no
// response; a vertex gives one response on rsp_ with the blended position
// and the count of leading nonzero weights applied.
// The datapath is a five-stage pipeline: palette read, matrix products,
// transform sum and saturate, weight products, blend sum and saturate into
// the output register. A vertex raises rsp_tvalid once it is in the output
// register; one transaction is taken every cycle unless the receiver stalls.
// The palette is held as one ram per matrix word per influence lane, so all
// words of all four bones are read in the same cycle; a write is seen by
// any vertex accepted in a later cycle.
// When the receiver stalls, the whole pipeline holds and req_tready drops,
// so nothing is lost or repeated. Reset clears the stage valid bits and
// influence counts only; palette contents are undefined until written.
`include "assert_macros.svh"
module linear_blend_skinning_top #(
   parameter int unsigned NUM_BONES      = lbs_pkg::DEF_NUM_BONES,
   parameter int unsigned MAX_INFLUENCES = lbs_pkg::DEF_MAX_INFLUENCES
) (
   input  logic                               clock,
   input  logic                               reset,
   input  logic                               req_tvalid,
   output logic                               req_tready,
   // matrix_bone, matrix_element, matrix_value, pos_x, pos_y, pos_z,
   // bone_indices, blend_weights, zero pad
   input  logic [lbs_pkg::REQ_TDATA_W-1:0]    req_tdata,
   // cmd
   input  logic                               req_tuser,
   output logic                               rsp_tvalid,
   input  logic                               rsp_tready,
   // skinned_x, skinned_y, skinned_z, influences_used, zero pad
   output logic [lbs_pkg::RSP_TDATA_W-1:0]    rsp_tdata
);
   logic                                 advance;
   logic                                 accept;
   lbs_pkg::stage_ctl_type               fetch_ctl;
   lbs_pkg::stage_ctl_type               xf_ctl;
   lbs_pkg::stage_ctl_type               out_ctl;
   logic signed [lbs_pkg::COORD_W-1:0]   pos [lbs_pkg::AXES];
   logic signed [lbs_pkg::COORD_W-1:0]   mat [MAX_INFLUENCES][lbs_pkg::MAT_WORDS];
   logic                                 bone_ok [MAX_INFLUENCES];
   logic [lbs_pkg::WEIGHT_W-1:0]         fetch_w [MAX_INFLUENCES];
   logic [lbs_pkg::WEIGHT_W-1:0]         xf_w [MAX_INFLUENCES];
   logic signed [lbs_pkg::COORD_W-1:0]   xf [MAX_INFLUENCES][lbs_pkg::AXES];
   logic signed [lbs_pkg::COORD_W-1:0]   skinned [lbs_pkg::AXES];

   // pipeline moves whenever the output register is free or being drained
   assign advance    = !out_ctl.valid || rsp_tready;
   assign req_tready = advance;
   assign accept     = req_tvalid && advance;

   lbs_fetch #(.NUM_BONES(NUM_BONES), .MAX_INFLUENCES(MAX_INFLUENCES)) u_fetch (
      .clock          (clock),
      .reset          (reset),
      .advance        (advance),
      .accept         (accept),
      .cmd            (lbs_pkg::cmd_type'(req_tuser)),
      .matrix_bone    (req_tdata[lbs_pkg::REQ_BONE_LSB +: lbs_pkg::BONE_W]),
      .matrix_element (req_tdata[lbs_pkg::REQ_ELEM_LSB +: lbs_pkg::ELEM_W]),
      .matrix_value   (req_tdata[lbs_pkg::REQ_VALUE_LSB +: lbs_pkg::COORD_W]),
      .pos_x          (signed'(req_tdata[lbs_pkg::REQ_X_LSB +: lbs_pkg::COORD_W])),
      .pos_y          (signed'(req_tdata[lbs_pkg::REQ_Y_LSB +: lbs_pkg::COORD_W])),
      .pos_z          (signed'(req_tdata[lbs_pkg::REQ_Z_LSB +: lbs_pkg::COORD_W])),
      .bone_indices   (req_tdata[lbs_pkg::REQ_IDX_LSB +: lbs_pkg::IDX_W]),
      .blend_weights  (req_tdata[lbs_pkg::REQ_WTS_LSB +: lbs_pkg::WTS_W]),
      .ctl            (fetch_ctl),
      .pos            (pos),
      .mat            (mat),
      .bone_ok        (bone_ok),
      .weight         (fetch_w)
   );

   lbs_xform #(.MAX_INFLUENCES(MAX_INFLUENCES)) u_xform (
      .clock    (clock),
      .reset    (reset),
      .advance  (advance),
      .ctl_i    (fetch_ctl),
      .pos      (pos),
      .mat      (mat),
      .bone_ok  (bone_ok),
      .weight_i (fetch_w),
      .ctl_o    (xf_ctl),
      .xf       (xf),
      .weight_o (xf_w)
   );

   lbs_blend #(.MAX_INFLUENCES(MAX_INFLUENCES)) u_blend (
      .clock   (clock),
      .reset   (reset),
      .advance (advance),
      .ctl_i   (xf_ctl),
      .xf      (xf),
      .weight  (xf_w),
      .ctl_o   (out_ctl),
      .skinned (skinned)
   );

   // response transaction
   assign rsp_tvalid = out_ctl.valid;
   assign rsp_tdata  = {{(lbs_pkg::RSP_TDATA_W - 3*lbs_pkg::COORD_W - lbs_pkg::COUNT_W){1'b0}},
                        out_ctl.used, skinned[2], skinned[1], skinned[0]};

   // checks
   `ASSERT_IMPLIES(a_used_bound, clock, reset, rsp_tvalid,
                   out_ctl.used <= lbs_pkg::COUNT_W'(MAX_INFLUENCES))
   `ASSERT_IMPLIES(a_no_influence_zero, clock, reset,
                   rsp_tvalid && (out_ctl.used == '0),
                   skinned[0] == '0 && skinned[1] == '0 && skinned[2] == '0)
   `ASSERT_NEXT(a_stall_freezes, clock, reset, !advance,
                $stable(fetch_ctl) && $stable(xf_ctl))
endmodule

>>> test/tb_top.sv
// testbench for the linear blend skinning block: directed and random palette and vertex transactions
`timescale 1ns / 1ps
module tb_top;
   localparam int unsigned WATCHDOG_LIMIT = 2000;
   localparam int unsigned DRAIN_CYCLES   = 12;
   localparam int unsigned PAL_WORDS      = lbs_pkg::DEF_NUM_BONES * lbs_pkg::MAT_WORDS;

   logic                            clock;
   logic                            reset;
   logic                            req_tvalid;
   logic                            req_tready;
   logic [lbs_pkg::REQ_TDATA_W-1:0] req_tdata;
   logic                            req_tuser;
   logic                            rsp_tvalid;
   logic                            rsp_tready = 1'b0;
   logic [lbs_pkg::RSP_TDATA_W-1:0] rsp_tdata;

   // fields from the lowest bit up: x, y, z, used
   typedef struct packed {
      logic [2:0]         used;
      logic signed [31:0] sz;
      logic signed [31:0] sy;
      logic signed [31:0] sx;
   } skinned_type;

   // predictor copy of the palette, with a written flag per word
   logic [31:0] palette_model [PAL_WORDS];
   bit          palette_set   [PAL_WORDS];
   skinned_type skinned_queue [$];
   int          error_count = 0;
   bit          rsp_idle_allowed;
   int unsigned quiet_cycles = 0;

   linear_blend_skinning_top dut (
      .clock      (clock),
      .reset      (reset),
      .req_tvalid (req_tvalid),
      .req_tready (req_tready),
      .req_tdata  (req_tdata),
      .req_tuser  (req_tuser),
      .rsp_tvalid (rsp_tvalid),
      .rsp_tready (rsp_tready),
      .rsp_tdata  (rsp_tdata)
   );

   initial begin
      clock = 1'b0;
      forever #6 clock = ~clock;
   end

   // floor of v / 2^k on a wide signed value
   function automatic logic signed [127:0] floor_shr(input logic signed [127:0] v, input int k);
      floor_shr = v >>> k;
   endfunction

   function automatic logic signed [127:0] clamp32(input logic signed [127:0] v);
      if (v > 128'sd2147483647) clamp32 = 128'sd2147483647;
      else if (v < -128'sd2147483648) clamp32 = -128'sd2147483648;
      else clamp32 = v;
   endfunction

   function automatic logic signed [127:0] palette_word(input int bone, input int idx);
      palette_word = 128'(signed'(palette_model[bone*lbs_pkg::MAT_WORDS+idx]));
   endfunction

   function automatic skinned_type blend_vertex(input logic [31:0] px, input logic [31:0] py,
                                                 input logic [31:0] pz, input logic [31:0] idxs,
                                                 input logic [62:0] wts);
      logic signed [127:0] pos [3];
      logic signed [127:0] acc [3];
      logic signed [127:0] t;
      logic signed [127:0] w;
      logic [63:0]         wts64;
      int                  bone;
      skinned_type         res;
      pos[0] = 128'(signed'(px));
      pos[1] = 128'(signed'(py));
      pos[2] = 128'(signed'(pz));
      acc = '{default: '0};
      wts64 = {1'b0, wts};
      res.used = '0;
      for (int i = 0; i < lbs_pkg::DEF_MAX_INFLUENCES; i++) begin
         w = 128'(wts64[16*i +: 16]);
         if (w == 0) break;
         bone = int'(idxs[8*i +: 8]);
         for (int r = 0; r < lbs_pkg::AXES; r++) begin
            t = palette_word(bone, r*4+lbs_pkg::TRANS_COL);
            for (int c = 0; c < 3; c++)
               t += floor_shr(palette_word(bone, r*4+c) * pos[c], lbs_pkg::MAT_FRAC);
            t = clamp32(t);
            acc[r] += floor_shr(t * w, lbs_pkg::WEIGHT_FRAC);
         end
         res.used++;
      end
      res.sx = 32'(clamp32(acc[0]));
      res.sy = 32'(clamp32(acc[1]));
      res.sz = 32'(clamp32(acc[2]));
      return res;
   endfunction

   task automatic report_mismatch(input string what, input logic [31:0] got,
                                  input logic [31:0] want);
      $display("mismatch %s: got %h expected %h", what, got, want);
      error_count++;
   endtask

   // drives one transaction and holds it until accepted
   task automatic send_item(input lbs_pkg::cmd_type cmd, input logic [7:0] bone,
                            input logic [3:0] elem,
                            input logic [31:0] value, input logic [31:0] px,
                            input logic [31:0] py, input logic [31:0] pz,
                            input logic [31:0] idxs, input logic [62:0] wts,
                            input bit allow_idle);
      logic [lbs_pkg::REQ_TDATA_W-1:0] d;
      skinned_type                     exp_res;
      if (allow_idle && $urandom_range(0, 3) == 0) begin
         req_tvalid <= 1'b0;
         repeat ($urandom_range(1, 3)) @(posedge clock);
      end
      d = '0;
      d[lbs_pkg::REQ_BONE_LSB +: 8]   = bone;
      d[lbs_pkg::REQ_ELEM_LSB +: 4]   = elem;
      d[lbs_pkg::REQ_VALUE_LSB +: 32] = value;
      d[lbs_pkg::REQ_X_LSB +: 32]     = px;
      d[lbs_pkg::REQ_Y_LSB +: 32]     = py;
      d[lbs_pkg::REQ_Z_LSB +: 32]     = pz;
      d[lbs_pkg::REQ_IDX_LSB +: 32]   = idxs;
      d[lbs_pkg::REQ_WTS_LSB +: 63]   = wts;
      req_tvalid <= 1'b1;
      req_tuser  <= cmd;
      req_tdata  <= d;
      do @(posedge clock); while (!req_tready);
      // predict at acceptance
      if (cmd == lbs_pkg::CMD_PALETTE) begin
         if (elem < lbs_pkg::MAT_WORDS) begin
            palette_model[bone*lbs_pkg::MAT_WORDS+elem] = value;
            palette_set[bone*lbs_pkg::MAT_WORDS+elem] = 1'b1;
         end
      end else begin
         exp_res = blend_vertex(px, py, pz, idxs, wts);
         skinned_queue = {skinned_queue, exp_res};
      end
   endtask

   task automatic write_matrix(input int bone, input bit allow_idle, input bit unit);
      logic [31:0] v;
      for (int e = 0; e < lbs_pkg::MAT_WORDS; e++) begin
         if (unit) v = (e % 5 == 0) ? 32'h0001_0000 : 32'h0000_0000;
         else if ($urandom_range(0, 5) == 0) v = $urandom;
         else v = $urandom_range(0, 32'h0003_0000) - 32'h0001_8000;
         send_item(lbs_pkg::CMD_PALETTE, 8'(bone), 4'(e), v, $urandom, $urandom, $urandom,
                   $urandom, 63'({$urandom, $urandom}), allow_idle);
      end
   endtask

   // picks a bone whose first matrix word has been written
   function automatic logic [7:0] loaded_bone();
      logic [7:0] b;
      do b = 8'($urandom_range(0, 255)); while (!palette_set[b*lbs_pkg::MAT_WORDS]);
      return b;
   endfunction

   task automatic send_vertex(input logic [31:0] px, input logic [31:0] py, input logic [31:0] pz,
                              input int n, input logic [62:0] wts_in, input bit allow_idle);
      logic [31:0] idxs;
      logic [63:0] wts64;
      idxs = $urandom;
      wts64 = {1'b0, wts_in};
      for (int i = 0; i < 4; i++) begin
         if (i < n) idxs[8*i +: 8] = loaded_bone();
         if (i == n) wts64[16*i +: 16] = '0;
      end
      send_item(lbs_pkg::CMD_VERTEX, 8'($urandom), 4'($urandom), $urandom, px, py, pz, idxs,
                wts64[62:0], allow_idle);
   endtask

   task automatic wait_drained();
      req_tvalid <= 1'b0;
      @(posedge clock);
      while (skinned_queue.size() != 0) @(posedge clock);
   endtask

   task automatic test_directed();
      // identity bone, a random bone and a full-scale bone
      write_matrix(0, 1'b0, 1'b1);
      write_matrix(255, 1'b0, 1'b0);
      for (int e = 0; e < lbs_pkg::MAT_WORDS; e++)
         send_item(lbs_pkg::CMD_PALETTE, 8'd1, 4'(e), (e % 2) ? 32'h8000_0000 : 32'h7fff_ffff,
                   0, 0, 0, 0, 0, 0);
      // element above 11 is ignored
      send_item(lbs_pkg::CMD_PALETTE, 8'd0, 4'd12, 32'hdead_beef, 0, 0, 0, 0, 0, 0);
      send_item(lbs_pkg::CMD_PALETTE, 8'd0, 4'd15, 32'hffff_ffff, 0, 0, 0, 0, 0, 0);
      // no influences
      send_item(lbs_pkg::CMD_VERTEX, 8'hff, 4'hf, 32'hffff_ffff, 32'h7fff_ffff, 32'h8000_0000,
                1, 0, 63'h7fff_ffff_ffff_0000, 0);
      // one identity influence, full weight
      send_item(lbs_pkg::CMD_VERTEX, 0, 0, 0, 32'h0001_0000, 32'hffff_0000, 32'h1234_5678,
                32'h0000_0000, 63'h0000_0000_0000_8000, 0);
      // saturation on extreme matrix and position, all four lanes, max weights; then mixed bones and weights
      send_item(lbs_pkg::CMD_VERTEX, 0, 0, 0, 32'h7fff_ffff, 32'h8000_0000, 32'h7fff_ffff,
                32'h01010101, 63'h7fff_ffff_ffff_ffff, 0);
      send_item(lbs_pkg::CMD_VERTEX, 0, 0, 0, 32'h8000_0000, 32'h8000_0000, 32'h8000_0000,
                32'hff01ff01, 63'h7fff_ffff_ffff_ffff, 0);
      send_item(lbs_pkg::CMD_VERTEX, 0, 0, 0, 32'h0000_0001, 32'hffff_ffff, 32'h0,
                32'h00ff0100, 63'h0001_0001_0001_0001, 0);
      send_item(lbs_pkg::CMD_VERTEX, 0, 0, 0, 32'h0, 32'h0, 32'h0, 32'h0000ff00,
                63'h0000_0000_ffff_0001, 0);
      wait_drained();
   endtask

   task automatic test_random(input int count, input bit allow_idle);
      for (int i = 0; i < count; i++) begin
         if ($urandom_range(0, 19) == 0)
            write_matrix(int'($urandom_range(0, 255)), allow_idle, 1'b0);
         else if ($urandom_range(0, 9) == 0)
            send_item(lbs_pkg::CMD_PALETTE, 8'($urandom), 4'($urandom_range(12, 15)), $urandom,
                      $urandom, $urandom, $urandom, $urandom, 63'({$urandom, $urandom}),
                      allow_idle);
         else
            send_vertex($urandom_range(0, 3) == 0 ? $urandom : $urandom_range(0, 32'h0010_0000)
                        - 32'h0008_0000, $urandom, $urandom_range(0, 32'h0040_0000),
                        int'($urandom_range(0, 4)),
                        63'({$urandom, $urandom}) | 63'h0001_0001_0001_0001, allow_idle);
      end
   endtask

   // response side: random stalls while allowed, checking against the oldest expectation
   always @(posedge clock) begin
      skinned_type got;
      skinned_type want;
      if (reset) begin
         rsp_tready <= 1'b0;
      end else begin
         if (rsp_tvalid && rsp_tready) begin
            quiet_cycles <= 0;
            got = rsp_tdata[98:0];
            if (skinned_queue.size() == 0) begin
               report_mismatch("unexpected response", got.sx, '0);
            end else begin
               want = skinned_queue.pop_front();
               if (got.sx !== want.sx) report_mismatch("skinned_x", got.sx, want.sx);
               if (got.sy !== want.sy) report_mismatch("skinned_y", got.sy, want.sy);
               if (got.sz !== want.sz) report_mismatch("skinned_z", got.sz, want.sz);
               if (got.used !== want.used)
                  report_mismatch("influences_used", 32'(got.used), 32'(want.used));
            end
         end else if (req_tvalid && req_tready) begin
            quiet_cycles <= 0;
         end else begin
            quiet_cycles <= quiet_cycles + 1;
         end
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("tb: failure");
            $finish;
         end
         rsp_tready <= rsp_idle_allowed ? ($urandom_range(0, 3) != 0) : 1'b1;
      end
   end

   initial begin
      reset = 1'b1;
      req_tvalid = 1'b0;
      req_tuser = 1'b0;
      req_tdata = '0;
      rsp_idle_allowed = 1'b1;
      for (int i = 0; i < PAL_WORDS; i++) begin
         palette_model[i] = '0;
         palette_set[i] = 1'b0;
      end
      repeat (4) @(posedge clock);
      reset <= 1'b0;
      @(posedge clock);
      test_directed();
      for (int b = 2; b < 7; b++) write_matrix(int'($urandom_range(2, 254)), 1'b1, 1'b0);
      test_random(180, 1'b1);
      // sender holds off until the pipeline is empty
      wait_drained();
      test_random(90, 1'b1);
      rsp_idle_allowed = 1'b0;
      test_random(70, 1'b0);
      wait_drained();
      repeat (DRAIN_CYCLES) @(posedge clock);
      if (error_count == 0) $display("tb: success");
      else $display("tb: failure");
      $finish;
   end
endmodule
